>>> hw/rtl/implicit_heat_forward_sweep_macros.svh
// Assertion helpers used by the top-level RTL file.
`ifndef IMPLICIT_HEAT_FORWARD_SWEEP_MACROS_SVH
`define IMPLICIT_HEAT_FORWARD_SWEEP_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define IHFS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define IHFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/ihfs_pkg.sv
`default_nettype none

package ihfs_pkg;

  localparam int unsigned QuotBits = 32;              // quotient bits per divide
  localparam int unsigned CntW     = $clog2(QuotBits);
  localparam int unsigned DenW     = 41;              // positive denominator
  localparam int unsigned SumW     = 42;              // signed den / num sums
  localparam int unsigned ProdW    = 64;              // s * prev product
  localparam int unsigned ShW      = ProdW - 24;      // product floored to Q.30 / Q16.16

  localparam logic [31:0] RatioReset = 32'd8388608;   // 0.5 in Q8.24
  localparam logic [31:0] Int32Min   = 32'h8000_0000;

  // sequencer steps
  typedef enum logic [2:0] {
    UPC_IDLE,
    UPC_MUL_C,
    UPC_MUL_D,
    UPC_NUM,
    UPC_LOAD,
    UPC_DIV,
    UPC_FIN
  } upc_e;

  // datapath action of a step
  typedef enum logic [2:0] {
    OP_IDLE,
    OP_MUL_C,
    OP_MUL_D,
    OP_NUM,
    OP_LOAD,
    OP_DIV,
    OP_FIN
  } op_e;

  // sequencing condition of a step
  typedef enum logic [2:0] {
    JC_NEXT,     // fall through
    JC_JUMP,     // go to target
    JC_ACCEPT,   // wait for a beat; boundary beats go to target
    JC_LOOP,     // go to target while the step count runs
    JC_EMIT      // go to target once the output register is free
  } jc_e;

  typedef struct packed {
    op_e  op;
    jc_e  jc;
    upc_e target;
  } uword_t;

  function automatic uword_t ucode(upc_e upc);
    uword_t w;
    case (upc)
      UPC_IDLE:  w = '{op: OP_IDLE,  jc: JC_ACCEPT, target: UPC_FIN};
      UPC_MUL_C: w = '{op: OP_MUL_C, jc: JC_NEXT,   target: UPC_MUL_D};
      UPC_MUL_D: w = '{op: OP_MUL_D, jc: JC_NEXT,   target: UPC_NUM};
      UPC_NUM:   w = '{op: OP_NUM,   jc: JC_NEXT,   target: UPC_LOAD};
      UPC_LOAD:  w = '{op: OP_LOAD,  jc: JC_NEXT,   target: UPC_DIV};
      UPC_DIV:   w = '{op: OP_DIV,   jc: JC_LOOP,   target: UPC_DIV};
      UPC_FIN:   w = '{op: OP_FIN,   jc: JC_EMIT,   target: UPC_IDLE};
      default:   w = '{op: OP_IDLE,  jc: JC_JUMP,   target: UPC_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/implicit_heat_forward_sweep.sv
// Flow: an interior point's beat is taken in UPC_IDLE, then the sequencer steps through
// UPC_MUL_C, UPC_MUL_D, UPC_NUM, UPC_LOAD and the shared 32-step restoring divider loop
// UPC_DIV to UPC_FIN, which registers the result once the output register is free. A boundary
// point goes from UPC_IDLE straight to UPC_FIN. The next beat is taken only back in UPC_IDLE.
// Reset: ratio = 0.5, previous coefficient and right-hand side = 0, pipeline empty.
`default_nettype none
`include "implicit_heat_forward_sweep_macros.svh"

module implicit_heat_forward_sweep #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        cfg_wr_en_i,
  input  wire logic [31:0] cfg_wr_data_i,    // diffusion_ratio, Q8.24

  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,     // [31:0] sample
  input  wire logic [0:0]  s_axis_tuser,     // [0] first_point
  input  wire logic        s_axis_tlast,     // last_point

  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,     // [31:0] upper_coef, [63:32] mod_rhs
  output logic             m_axis_tlast      // row_end
);

  localparam int unsigned RhsBits = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
  localparam logic [32:0] RhsHi   = (33'd1 << (RhsBits - 1)) - 33'd1;
  localparam logic [32:0] RhsLo   = ~RhsHi;
  localparam int unsigned QW      = ihfs_pkg::QuotBits;
  localparam int unsigned DW      = ihfs_pkg::DenW;
  localparam int unsigned SW      = ihfs_pkg::SumW;
  localparam int unsigned CW      = ihfs_pkg::CntW;
  localparam int unsigned HW      = ihfs_pkg::ShW;

  // control state
  ihfs_pkg::upc_e   upc_q, upc_d;
  ihfs_pkg::uword_t cw;
  logic [31:0]      ratio_q;
  logic [31:0]      prev_upper_q;
  logic [31:0]      prev_rhs_q;
  logic             out_valid_q;

  // payload
  logic [31:0]         sample_q;
  logic                bnd_q;
  logic                last_q;
  logic [ihfs_pkg::ProdW-1:0] prod_q;
  logic [DW-1:0]       den_q;
  logic                num_neg_q;
  logic [DW-1:0]       num_mag_q;
  logic [DW-1:0]       rem_c_q, rem_d_q;
  logic [QW-1:0]       quo_c_q, quo_d_q;
  logic [QW-1:0]       feed_d_q;
  logic                ovf_c_q, ovf_d_q;
  logic [CW-1:0]       cnt_q;
  logic [63:0]         out_data_q;
  logic                out_last_q;

  logic in_fire, out_free, emit, in_bnd;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign in_bnd   = s_axis_tuser[0] || s_axis_tlast;
  assign out_free = !out_valid_q || m_axis_tready;

  // ---------------- sequencer ----------------
  always_comb begin
    cw = ihfs_pkg::ucode(upc_q);
  end

  always_comb begin
    upc_d = upc_q;
    case (cw.jc)
      ihfs_pkg::JC_NEXT:   upc_d = ihfs_pkg::upc_e'(upc_q + 3'd1);
      ihfs_pkg::JC_JUMP:   upc_d = cw.target;
      ihfs_pkg::JC_ACCEPT: begin
        if (in_fire) begin
          upc_d = in_bnd ? cw.target : ihfs_pkg::upc_e'(upc_q + 3'd1);
        end
      end
      ihfs_pkg::JC_LOOP:   upc_d = (cnt_q != '0) ? cw.target
                                                 : ihfs_pkg::upc_e'(upc_q + 3'd1);
      ihfs_pkg::JC_EMIT:   begin
        if (out_free) begin
          upc_d = cw.target;
        end
      end
      default:             upc_d = ihfs_pkg::UPC_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (cw.op == ihfs_pkg::OP_IDLE) && (upc_q == ihfs_pkg::UPC_IDLE);
    emit          = (cw.op == ihfs_pkg::OP_FIN) && out_free;
  end

  // ---------------- datapath ----------------
  logic signed [31:0] mul_b;
  logic signed [64:0] mul_p;
  logic signed [HW-1:0] prod_sh;
  logic signed [SW-1:0] den_raw, num_raw, num_negv;
  logic [SW-1:0]        ahi_c, ahi_d;
  logic [DW:0]          trial_c, trial_d;
  logic                 take_c, take_d;
  logic [31:0]          c_fin, d_fin, neg_qd, neg_qc;
  logic signed [32:0]   samp_x;

  assign mul_b   = (cw.op == ihfs_pkg::OP_MUL_C) ? $signed(prev_upper_q)
                                                 : $signed(prev_rhs_q);
  assign mul_p   = $signed({1'b0, ratio_q}) * mul_b;
  assign prod_sh = $signed(prod_q[ihfs_pkg::ProdW-1:24]);   // floor by arithmetic shift

  assign den_raw = $signed(SW'(42'd1 << 30)) + $signed({3'b0, ratio_q, 7'b0})
                 + $signed({{(SW-HW){prod_sh[HW-1]}}, prod_sh});
  assign num_raw = $signed({{(SW-32){sample_q[31]}}, sample_q})
                 + $signed({{(SW-HW){prod_sh[HW-1]}}, prod_sh});
  assign num_negv = -num_raw;

  // high parts of the dividends s*2^36 and |num|*2^30 above the quotient bits
  assign ahi_c = {6'b0, ratio_q, 4'b0};
  assign ahi_d = {3'b0, num_mag_q[DW-1:2]};

  assign trial_c = {rem_c_q, 1'b0};
  assign trial_d = {rem_d_q, feed_d_q[QW-1]};
  assign take_c  = trial_c >= {1'b0, den_q};
  assign take_d  = trial_d >= {1'b0, den_q};

  assign neg_qc = ~quo_c_q + 32'd1;
  assign neg_qd = ~quo_d_q + 32'd1;
  assign samp_x = $signed({sample_q[31], sample_q});

  always_comb begin
    if (bnd_q) begin
      c_fin = '0;
      if (samp_x > $signed(RhsHi)) begin
        d_fin = RhsHi[31:0];
      end else if (samp_x < $signed(RhsLo)) begin
        d_fin = RhsLo[31:0];
      end else begin
        d_fin = sample_q;
      end
    end else begin
      c_fin = (ovf_c_q || quo_c_q[QW-1]) ? ihfs_pkg::Int32Min : neg_qc;
      if (num_neg_q) begin
        d_fin = (ovf_d_q || ({1'b0, quo_d_q} > (RhsHi + 33'd1))) ? RhsLo[31:0] : neg_qd;
      end else begin
        d_fin = (ovf_d_q || ({1'b0, quo_d_q} > RhsHi)) ? RhsHi[31:0] : quo_d_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q        <= ihfs_pkg::UPC_IDLE;
      ratio_q      <= ihfs_pkg::RatioReset;
      prev_upper_q <= '0;
      prev_rhs_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      upc_q <= upc_d;
      if (cfg_wr_en_i) begin
        ratio_q <= cfg_wr_data_i;
      end
      if (emit) begin
        prev_upper_q <= c_fin;
        prev_rhs_q   <= d_fin;
        out_valid_q  <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sample_q <= s_axis_tdata;
      bnd_q    <= in_bnd;
      last_q   <= s_axis_tlast;
    end
    case (cw.op)
      ihfs_pkg::OP_MUL_C: prod_q <= mul_p[ihfs_pkg::ProdW-1:0];
      ihfs_pkg::OP_MUL_D: begin
        prod_q <= mul_p[ihfs_pkg::ProdW-1:0];
        // a non-positive denominator is forced to 1
        den_q  <= (den_raw[SW-1] || den_raw == '0) ? DW'(1) : den_raw[DW-1:0];
      end
      ihfs_pkg::OP_NUM: begin
        num_neg_q <= num_raw[SW-1];
        num_mag_q <= num_raw[SW-1] ? num_negv[DW-1:0] : num_raw[DW-1:0];
      end
      ihfs_pkg::OP_LOAD: begin
        ovf_c_q  <= ahi_c >= {1'b0, den_q};
        ovf_d_q  <= ahi_d >= {1'b0, den_q};
        rem_c_q  <= (ahi_c >= {1'b0, den_q}) ? '0 : ahi_c[DW-1:0];
        rem_d_q  <= (ahi_d >= {1'b0, den_q}) ? '0 : ahi_d[DW-1:0];
        feed_d_q <= {num_mag_q[1:0], {(QW-2){1'b0}}};
        quo_c_q  <= '0;
        quo_d_q  <= '0;
        cnt_q    <= CW'(QW - 1);
      end
      ihfs_pkg::OP_DIV: begin
        rem_c_q  <= take_c ? DW'(trial_c - {1'b0, den_q}) : trial_c[DW-1:0];
        rem_d_q  <= take_d ? DW'(trial_d - {1'b0, den_q}) : trial_d[DW-1:0];
        quo_c_q  <= {quo_c_q[QW-2:0], take_c};
        quo_d_q  <= {quo_d_q[QW-2:0], take_d};
        feed_d_q <= {feed_d_q[QW-2:0], 1'b0};
        if (cnt_q != '0) begin
          cnt_q <= cnt_q - CW'(1);
        end
      end
      default: ;
    endcase
    if (emit) begin
      out_data_q <= {d_fin, c_fin};
      out_last_q <= last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  // ---------------- checks ----------------
  `IHFS_ASSERT_NEXT(a_div_exit, clk_i, rst_ni,
    (upc_q == ihfs_pkg::UPC_DIV) && (cnt_q == '0), upc_q == ihfs_pkg::UPC_FIN,
    "divider loop did not end after its last step")
  `IHFS_ASSERT_IMPL(a_rem_bound, clk_i, rst_ni,
    upc_q == ihfs_pkg::UPC_DIV, (rem_c_q < den_q) && (rem_d_q < den_q),
    "partial remainder not below denominator")
  `IHFS_ASSERT_IMPL(a_den_pos, clk_i, rst_ni,
    (upc_q == ihfs_pkg::UPC_LOAD) || (upc_q == ihfs_pkg::UPC_DIV), den_q != '0,
    "zero denominator reached the divider")
  `IHFS_ASSERT_NEXT(a_leave_idle, clk_i, rst_ni,
    in_fire, upc_q != ihfs_pkg::UPC_IDLE,
    "accepted beat did not start the sequencer")
  `IHFS_ASSERT_IMPL(a_out_src, clk_i, rst_ni,
    $rose(out_valid_q), $past(upc_q) == ihfs_pkg::UPC_FIN,
    "result beat raised outside the final step")

endmodule

`default_nettype wire
